@@ hdl/isoeuc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// isoeuc_pkg
// Shared codes, byte constants and the result bundle of the ISO 2022 7-bit
// to EUC-TW converter.
// ----------------------------------------------------------------------------
package isoeuc_pkg;

    localparam int MaxRes = 4;

    localparam logic OP_DATA  = 1'b0;
    localparam logic OP_RESET = 1'b1;

    localparam logic [7:0] C_ESC    = 8'h1b;
    localparam logic [7:0] C_SO     = 8'h0e;
    localparam logic [7:0] C_SI     = 8'h0f;
    localparam logic [7:0] C_HIGH   = 8'h80;
    localparam logic [7:0] C_SS2    = 8'h8e;
    localparam logic [7:0] C_PLN    = 8'ha0;
    localparam logic [7:0] C_DOLLAR = 8'h24;
    localparam logic [7:0] C_RPAR   = 8'h29;
    localparam logic [7:0] C_STAR   = 8'h2a;
    localparam logic [7:0] C_PL_LO  = 8'h47;
    localparam logic [7:0] C_PL_HI  = 8'h56;
    localparam logic [7:0] C_PL_OFS = 8'h46;

    typedef struct packed {
        logic [MaxRes-1:0][7:0] bytes;
        logic [2:0]             cnt;
    } t_res;

endpackage
`default_nettype wire

@@ hdl/isoeuc_step.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// isoeuc_step
// Escape/shift state machine; produces all result bytes of one item at once
// and advances the state when the item is taken.
// ----------------------------------------------------------------------------
module isoeuc_step (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_en,
    input  wire logic              i_op,
    input  wire logic [7:0]        i_byte,
    output isoeuc_pkg::t_res       o_res
);
    import isoeuc_pkg::*;

    typedef enum logic [2:0] {
        M_ASCII    = 3'd0,
        M_ESC      = 3'd1,
        M_ESC_DLR  = 3'd2,
        M_DESIG    = 3'd3,
        M_SHIFT_IN = 3'd4,
        M_CHINESE  = 3'd5,
        M_HELD_P1  = 3'd6,
        M_HELD_PN  = 3'd7
    } t_mode;

    t_mode       r_mode, n_mode;
    logic [4:0]  r_plane, n_plane;
    logic [7:0]  r_held, n_held;
    logic        r_star, n_star;

    logic        asc;
    logic [1:0]  pre;
    logic [7:0]  c_hi;
    logic [4:0]  pl_diff;
    t_res        res;

    assign c_hi    = i_byte | C_HIGH;
    assign pl_diff = i_byte[4:0] - C_PL_OFS[4:0];

    always_comb begin
        n_mode    = r_mode;
        n_plane   = r_plane;
        n_held    = r_held;
        n_star    = r_star;
        asc       = 1'b0;
        pre       = 2'd0;
        res.bytes = '0;
        res.cnt   = 3'd0;
        case (r_mode)
            M_ASCII: begin
                asc = 1'b1;
            end
            M_ESC: begin
                if (i_byte == C_DOLLAR) begin
                    n_mode = M_ESC_DLR;
                end else begin
                    pre = 2'd1;
                    asc = 1'b1;
                end
            end
            M_ESC_DLR: begin
                if (i_byte == C_RPAR || i_byte == C_STAR) begin
                    n_star = (i_byte == C_STAR);
                    n_mode = M_DESIG;
                end else begin
                    pre = 2'd2;
                    asc = 1'b1;
                end
            end
            M_DESIG: begin
                if (i_byte >= C_PL_LO && i_byte <= C_PL_HI) begin
                    n_plane = pl_diff;
                    n_mode  = M_SHIFT_IN;
                end else begin
                    pre = 2'd3;
                    asc = 1'b1;
                end
            end
            M_SHIFT_IN: begin
                if (i_byte == C_ESC) begin
                    n_mode = M_ESC;
                end else if (i_byte == C_SO) begin
                    n_mode = M_CHINESE;
                end else begin
                    res.bytes[0] = i_byte;
                    res.cnt      = 3'd1;
                    n_mode       = M_ASCII;
                end
            end
            M_CHINESE: begin
                if (i_byte == C_SI) begin
                    n_mode = M_SHIFT_IN;
                end else begin
                    n_held = c_hi;
                    n_mode = (r_plane == 5'd1) ? M_HELD_P1 : M_HELD_PN;
                end
            end
            M_HELD_P1: begin
                res.bytes[0] = r_held;
                res.bytes[1] = c_hi;
                res.cnt      = 3'd2;
                n_mode       = M_CHINESE;
            end
            M_HELD_PN: begin
                res.bytes[0] = C_SS2;
                res.bytes[1] = C_PLN + {3'b000, r_plane};
                res.bytes[2] = r_held;
                res.bytes[3] = c_hi;
                res.cnt      = 3'd4;
                n_mode       = M_CHINESE;
            end
            default: begin
                n_mode = M_ASCII;
            end
        endcase
        // broken escape replay, then the byte again from the ascii state
        if (asc) begin
            res.bytes[0] = C_ESC;
            res.bytes[1] = C_DOLLAR;
            res.bytes[2] = r_star ? C_STAR : C_RPAR;
            if (i_byte == C_ESC) begin
                res.cnt = {1'b0, pre};
                n_mode  = M_ESC;
            end else begin
                res.bytes[pre] = i_byte;
                res.cnt        = {1'b0, pre} + 3'd1;
                n_mode         = M_ASCII;
            end
        end
        if (i_op == OP_RESET) begin
            n_mode  = M_ASCII;
            n_plane = r_plane;
            n_held  = r_held;
            n_star  = r_star;
            res.cnt = 3'd0;
        end
    end

    assign o_res = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= M_ASCII;
            r_plane <= 5'd0;
            r_star  <= 1'b0;
        end else if (i_en) begin
            r_mode  <= n_mode;
            r_plane <= n_plane;
            r_star  <= n_star;
        end
        if (i_en) begin
            r_held <= n_held;
        end
    end

endmodule
`default_nettype wire

@@ hdl/iso2022_7bit_to_euc_tw_converter_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// iso2022_7bit_to_euc_tw_converter_core
// Converts a stream of 7-bit ISO 2022 bytes to EUC-TW bytes, up to four
// result bytes per item.
//
// channel  direction  handshake         payload
// input    in         i_valid/o_stall   i_op, i_in_byte
// result   out        o_valid/i_stall   o_out_byte, o_last
//
// an item enters the input register; once the result buffer is free, the state
// machine turns it into its result bytes in the result buffer
// the result buffer sends one byte per cycle while i_stall is low; an item
// gives no result bytes for the first byte of a character, two for the second
// byte of a plane 1 character, four for the second byte of a character of
// another plane
// a new item is taken while the buffer still holds results
// reset is synchronous and returns to the ascii state with empty buffers
// ----------------------------------------------------------------------------
module iso2022_7bit_to_euc_tw_converter_core (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire logic       i_op,
    input  wire logic [7:0] i_in_byte,
    output logic            o_valid,
    input  wire logic       i_stall,
    output logic [7:0]      o_out_byte,
    output logic            o_last
);
    import isoeuc_pkg::*;

    logic                    r_in_vld;
    logic                    r_in_op;
    logic [7:0]              r_in_byte;
    logic [MaxRes-1:0][7:0]  r_buf;
    logic [2:0]              r_rem;

    logic                    buf_free;
    logic                    move;
    logic                    in_acc;
    logic                    out_acc;
    t_res                    res;

    isoeuc_step u_step (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (move),
        .i_op    (r_in_op),
        .i_byte  (r_in_byte),
        .o_res   (res)
    );

    assign o_valid    = (r_rem != 3'd0);
    assign o_out_byte = r_buf[0];
    assign o_last     = (r_rem == 3'd1);
    assign out_acc    = o_valid && !i_stall;
    assign buf_free   = (r_rem == 3'd0) || (r_rem == 3'd1 && !i_stall);
    assign move       = r_in_vld && buf_free;
    assign o_stall    = r_in_vld && !buf_free;
    assign in_acc     = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
            r_rem    <= 3'd0;
        end else begin
            if (in_acc) begin
                r_in_vld <= 1'b1;
            end else if (move) begin
                r_in_vld <= 1'b0;
            end
            if (move) begin
                r_rem <= res.cnt;
            end else if (out_acc) begin
                r_rem <= r_rem - 3'd1;
            end
        end
        if (in_acc) begin
            r_in_op   <= i_op;
            r_in_byte <= i_in_byte;
        end
        if (move) begin
            r_buf <= res.bytes;
        end else if (out_acc) begin
            r_buf <= {8'h00, r_buf[MaxRes-1:1]};
        end
    end

endmodule
`default_nettype wire
